### rtl/baro_pressure_temp_compensation_unit_assert.svh
// Assertion macros used by the compensation unit checker.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bptc_pkg.sv
// Shared constants, register codes and helper functions of the compensation unit.
package bptc_pkg;

   localparam int unsigned PIPE_DEPTH = 16;
   localparam int unsigned CSR_ADDR_W = 5;

   // Reciprocal of 31 at 29 fractional bits, rounded up; exact quotient for 24-bit operands.
   localparam logic [24:0] RECIP31 = 25'd17318417;

   localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] OUT_MIN = 24'sh800000;
   localparam logic [43:0] POS_LIMIT = 44'd8388607;
   localparam logic [43:0] NEG_LIMIT = 44'd8388608;

   typedef enum logic [2:0] {
      REG_TEMP_COEFFS = 3'd0,
      REG_PRESS_OFFSET = 3'd1,
      REG_PRESS_LIN = 3'd2,
      REG_TEMP_CROSS = 3'd3,
      REG_CROSS_LIN = 3'd4,
      REG_PRESS_QUAD = 3'd5,
      REG_CROSS_QUAD = 3'd6,
      REG_PRESS_CUBIC = 3'd7
   } reg_index_type;

   // floor((2048 * rem + 15) / 31) for a remainder of a division by 31.
   function automatic logic [10:0] frac_step(input logic [4:0] rem);
      logic [10:0] res;
      case (rem)
         5'd0: res = 11'd0;
         5'd1: res = 11'd66;
         5'd2: res = 11'd132;
         5'd3: res = 11'd198;
         5'd4: res = 11'd264;
         5'd5: res = 11'd330;
         5'd6: res = 11'd396;
         5'd7: res = 11'd462;
         5'd8: res = 11'd529;
         5'd9: res = 11'd595;
         5'd10: res = 11'd661;
         5'd11: res = 11'd727;
         5'd12: res = 11'd793;
         5'd13: res = 11'd859;
         5'd14: res = 11'd925;
         5'd15: res = 11'd991;
         5'd16: res = 11'd1057;
         5'd17: res = 11'd1123;
         5'd18: res = 11'd1189;
         5'd19: res = 11'd1255;
         5'd20: res = 11'd1321;
         5'd21: res = 11'd1387;
         5'd22: res = 11'd1453;
         5'd23: res = 11'd1519;
         5'd24: res = 11'd1586;
         5'd25: res = 11'd1652;
         5'd26: res = 11'd1718;
         5'd27: res = 11'd1784;
         5'd28: res = 11'd1850;
         5'd29: res = 11'd1916;
         5'd30: res = 11'd1982;
         default: res = 11'd0;
      endcase
      return res;
   endfunction

   // Applies the sign to a rounded magnitude and clamps to 24-bit signed; top bit flags a clamp.
   function automatic logic [24:0] clamp_out(input logic neg, input logic [43:0] mag);
      logic [24:0] res;
      if (!neg) begin
         if (mag > POS_LIMIT) begin
            res = {1'b1, OUT_MAX};
         end else begin
            res = {1'b0, mag[23:0]};
         end
      end else begin
         if (mag > NEG_LIMIT) begin
            res = {1'b1, OUT_MIN};
         end else begin
            res = {1'b0, ~mag[23:0] + 24'd1};
         end
      end
      return res;
   endfunction

endpackage

### rtl/baro_pressure_temp_compensation_unit.sv
// Barometric pressure and temperature compensation: pipelined polynomial datapath.
// Throughput: one reading pair per cycle while rsp_tready does not stall the output.
// Each stage holds only while the one after it is full.
// Wide products are split into two partial products per stage, so the multiply chain sets depth.
// Reset clears all stage valid bits and sets every coefficient register to zero.
module baro_pressure_temp_compensation_unit
   import bptc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // raw_temp [23:0], raw_press [47:24]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // comp_press [23:0], comp_temp [47:24]
   output logic                  rsp_tuser,   // clipped [0]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Coefficient registers.
   logic [23:0]        temp_coeffs_ff;
   logic signed [19:0] press_offset_ff;
   logic signed [19:0] press_lin_ff;
   logic signed [15:0] temp_cross_ff;
   logic signed [15:0] cross_lin_ff;
   logic signed [15:0] press_quad_ff;
   logic signed [15:0] cross_quad_ff;
   logic signed [15:0] press_cubic_ff;
   logic signed [11:0] coef_c0;
   logic signed [11:0] coef_c1;
   logic               csr_wr;
   reg_index_type      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx = reg_index_type'(csr_paddr[4:2]);
   assign coef_c0 = $signed(temp_coeffs_ff[23:12]);
   assign coef_c1 = $signed(temp_coeffs_ff[11:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_offset_ff <= '0;
         press_lin_ff <= '0;
         temp_cross_ff <= '0;
         cross_lin_ff <= '0;
         press_quad_ff <= '0;
         cross_quad_ff <= '0;
         press_cubic_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TEMP_COEFFS: temp_coeffs_ff <= csr_pwdata[23:0];
            REG_PRESS_OFFSET: press_offset_ff <= $signed(csr_pwdata[19:0]);
            REG_PRESS_LIN: press_lin_ff <= $signed(csr_pwdata[19:0]);
            REG_TEMP_CROSS: temp_cross_ff <= $signed(csr_pwdata[15:0]);
            REG_CROSS_LIN: cross_lin_ff <= $signed(csr_pwdata[15:0]);
            REG_PRESS_QUAD: press_quad_ff <= $signed(csr_pwdata[15:0]);
            REG_CROSS_QUAD: cross_quad_ff <= $signed(csr_pwdata[15:0]);
            REG_PRESS_CUBIC: press_cubic_ff <= $signed(csr_pwdata[15:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TEMP_COEFFS: csr_prdata = 32'(temp_coeffs_ff);
         REG_PRESS_OFFSET: csr_prdata = 32'(press_offset_ff);
         REG_PRESS_LIN: csr_prdata = 32'(press_lin_ff);
         REG_TEMP_CROSS: csr_prdata = 32'(temp_cross_ff);
         REG_CROSS_LIN: csr_prdata = 32'(cross_lin_ff);
         REG_PRESS_QUAD: csr_prdata = 32'(press_quad_ff);
         REG_CROSS_QUAD: csr_prdata = 32'(cross_quad_ff);
         REG_PRESS_CUBIC: csr_prdata = 32'(press_cubic_ff);
         default: csr_prdata = '0;
      endcase
   end

   // Stage valid bits and per-stage load enables. A stage loads when it is empty or
   // when the stage after it moves on, so bubbles collapse during a stall.
   logic [PIPE_DEPTH:1] vld_ff;
   logic [PIPE_DEPTH:1] vld_in;
   logic [PIPE_DEPTH:1] stage_en;

   always_comb begin
      stage_en[PIPE_DEPTH] = !vld_ff[PIPE_DEPTH] || rsp_tready;
      for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign vld_in = {vld_ff[PIPE_DEPTH-1:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_ff & ~stage_en) | (vld_in & stage_en);
      end
   end

   assign req_tready = stage_en[1];

   // Values carried unchanged along several stages.
   logic               t_neg_ff [1:8];
   logic               p_neg_ff [1:8];
   logic [29:0]        t_mag_ff [2:9];
   logic [29:0]        p_mag_ff [2:9];
   logic signed [46:0] c01t_ff [3:12];
   logic signed [23:0] temp_ff [7:15];
   logic               tclip_ff [7:15];

   // Stage 1: magnitudes and quotient by 31.
   logic [23:0] raw_t;
   logic [23:0] raw_p;
   logic [23:0] t_rmag1_in, p_rmag1_in, t_rmag1_ff, p_rmag1_ff;
   logic [48:0] t_qprod, p_qprod;
   logic [18:0] t_q1_in, p_q1_in, t_q1_ff, p_q1_ff;

   assign raw_t = req_tdata[23:0];
   assign raw_p = req_tdata[47:24];
   assign t_rmag1_in = raw_t[23] ? (~raw_t + 24'd1) : raw_t;
   assign p_rmag1_in = raw_p[23] ? (~raw_p + 24'd1) : raw_p;
   assign t_qprod = t_rmag1_in * RECIP31;
   assign p_qprod = p_rmag1_in * RECIP31;
   assign t_q1_in = t_qprod[47:29];
   assign p_q1_in = p_qprod[47:29];

   // Stage 2: scaled magnitude is 2048 * quotient plus a table step for the remainder.
   logic [23:0]        t_rem_full, p_rem_full;
   logic [29:0]        t_mag2_in, p_mag2_in;
   logic signed [30:0] t_s2_in, p_s2_in, t_s2_ff, p_s2_ff;

   assign t_rem_full = t_rmag1_ff - {t_q1_ff, 5'd0} + {5'd0, t_q1_ff};
   assign p_rem_full = p_rmag1_ff - {p_q1_ff, 5'd0} + {5'd0, p_q1_ff};
   assign t_mag2_in = {t_q1_ff, frac_step(t_rem_full[4:0])};
   assign p_mag2_in = {p_q1_ff, frac_step(p_rem_full[4:0])};
   assign t_s2_in = t_neg_ff[1] ? -$signed({1'b0, t_mag2_in}) : $signed({1'b0, t_mag2_in});
   assign p_s2_in = p_neg_ff[1] ? -$signed({1'b0, p_mag2_in}) : $signed({1'b0, p_mag2_in});

   // Stage 3: coefficient products of the scaled readings.
   logic signed [46:0] c30p3_in, c21p3_in, c30p3_ff, c21p3_ff, c01t3_in;
   logic signed [42:0] c1t3_in, c1t3_ff;

   assign c30p3_in = press_cubic_ff * p_s2_ff;
   assign c21p3_in = cross_quad_ff * p_s2_ff;
   assign c01t3_in = temp_cross_ff * t_s2_ff;
   assign c1t3_in = coef_c1 * t_s2_ff;

   // Stage 4: add aligned coefficients.
   logic signed [47:0] h1_4_in, g1_4_in, h1_4_ff, g1_4_ff;
   logic signed [43:0] tacc4_in, tacc4_ff;

   assign h1_4_in = $signed({press_quad_ff, 24'd0}) + c30p3_ff;
   assign g1_4_in = $signed({cross_lin_ff, 24'd0}) + c21p3_ff;
   assign tacc4_in = $signed({coef_c0, 23'd0}) + c1t3_ff;

   // Stage 5: split into sign and magnitude for the rounded products.
   logic [46:0] h1m5_in, g1m5_in, h1m5_ff, g1m5_ff;
   logic        hn5_in, gn5_in, hn5_ff, gn5_ff;
   logic [42:0] tm5_in, tm5_ff;
   logic        tn5_ff;

   assign h1m5_in = h1_4_ff[47] ? 47'(-h1_4_ff) : h1_4_ff[46:0];
   assign g1m5_in = g1_4_ff[47] ? 47'(-g1_4_ff) : g1_4_ff[46:0];
   assign hn5_in = h1_4_ff[47] ^ p_neg_ff[4];
   assign gn5_in = g1_4_ff[47] ^ p_neg_ff[4];
   assign tm5_in = tacc4_ff[43] ? 43'(-tacc4_ff) : tacc4_ff[42:0];

   // Stage 6: partial products of Ps by the first inner terms; temperature rounding.
   logic [53:0] hlo6_in, glo6_in, hlo6_ff, glo6_ff;
   logic [52:0] hhi6_in, ghi6_in, hhi6_ff, ghi6_ff;
   logic        hn6_ff, gn6_ff, tn6_ff;
   logic [43:0] tr_sum;
   logic [27:0] tr6_in, tr6_ff;

   assign hlo6_in = p_mag_ff[5] * h1m5_ff[23:0];
   assign hhi6_in = p_mag_ff[5] * h1m5_ff[46:24];
   assign glo6_in = p_mag_ff[5] * g1m5_ff[23:0];
   assign ghi6_in = p_mag_ff[5] * g1m5_ff[46:24];
   assign tr_sum = {1'b0, tm5_ff} + 44'h8000;
   assign tr6_in = tr_sum[43:16];

   // Stage 7: combine partial products, round by 24 bits; clamp temperature.
   logic [76:0] hfull7, gfull7;
   logic [52:0] hm7_in, gm7_in, hm7_ff, gm7_ff;
   logic        hn7_ff, gn7_ff;
   logic [24:0] temp7_in;

   assign hfull7 = 77'(hlo6_ff) + {hhi6_ff, 24'd0} + 77'h800000;
   assign gfull7 = 77'(glo6_ff) + {ghi6_ff, 24'd0} + 77'h800000;
   assign hm7_in = hfull7[76:24];
   assign gm7_in = gfull7[76:24];
   assign temp7_in = clamp_out(tn6_ff, 44'(tr6_ff));

   // Stage 8: restore signs and add the linear pressure coefficient.
   logic signed [53:0] hs8, g2_8_in, h2_8_in, h2_8_ff, g2_8_ff;

   assign hs8 = hn7_ff ? -$signed({1'b0, hm7_ff}) : $signed({1'b0, hm7_ff});
   assign g2_8_in = gn7_ff ? -$signed({1'b0, gm7_ff}) : $signed({1'b0, gm7_ff});
   assign h2_8_in = $signed({press_lin_ff, 24'd0}) + hs8;

   // Stage 9: sign and magnitude for the outer products.
   logic [52:0] h2m9_in, g2m9_in, h2m9_ff, g2m9_ff;
   logic        hn9_in, gn9_in, hn9_ff, gn9_ff;

   assign h2m9_in = h2_8_ff[53] ? 53'(-h2_8_ff) : h2_8_ff[52:0];
   assign g2m9_in = g2_8_ff[53] ? 53'(-g2_8_ff) : g2_8_ff[52:0];
   assign hn9_in = h2_8_ff[53] ^ p_neg_ff[8];
   assign gn9_in = g2_8_ff[53] ^ t_neg_ff[8];

   // Stage 10: partial products of Ps and Ts by the outer terms.
   logic [55:0] hlo10_in, glo10_in, hlo10_ff, glo10_ff;
   logic [56:0] hhi10_in, ghi10_in, hhi10_ff, ghi10_ff;
   logic        hn10_ff, gn10_ff;

   assign hlo10_in = p_mag_ff[9] * h2m9_ff[25:0];
   assign hhi10_in = p_mag_ff[9] * h2m9_ff[52:26];
   assign glo10_in = t_mag_ff[9] * g2m9_ff[25:0];
   assign ghi10_in = t_mag_ff[9] * g2m9_ff[52:26];

   // Stage 11: combine and round by 24 bits.
   logic [82:0] hfull11, gfull11;
   logic [58:0] h3m11_in, g3m11_in, h3m11_ff, g3m11_ff;
   logic        hn11_ff, gn11_ff;

   assign hfull11 = 83'(hlo10_ff) + {hhi10_ff, 26'd0} + 83'h800000;
   assign gfull11 = 83'(glo10_ff) + {ghi10_ff, 26'd0} + 83'h800000;
   assign h3m11_in = hfull11[82:24];
   assign g3m11_in = gfull11[82:24];

   // Stage 12: restore signs.
   logic signed [59:0] h3_12_in, g3_12_in, h3_12_ff, g3_12_ff;

   assign h3_12_in = hn11_ff ? -$signed({1'b0, h3m11_ff}) : $signed({1'b0, h3m11_ff});
   assign g3_12_in = gn11_ff ? -$signed({1'b0, g3m11_ff}) : $signed({1'b0, g3m11_ff});

   // Stage 13: pressure accumulator.
   logic signed [61:0] acc13_in, acc13_ff;

   assign acc13_in = $signed({press_offset_ff, 24'd0}) + h3_12_ff + g3_12_ff + c01t_ff[12];

   // Stage 14: accumulator magnitude.
   logic [60:0] am14_in, am14_ff;
   logic        an14_ff;

   assign am14_in = acc13_ff[61] ? 61'(-acc13_ff) : acc13_ff[60:0];

   // Stage 15: round pressure by 18 bits.
   logic [61:0] pr_sum;
   logic [43:0] pr15_in, pr15_ff;
   logic        an15_ff;

   assign pr_sum = {1'b0, am14_ff} + 62'h20000;
   assign pr15_in = pr_sum[61:18];

   // Stage 16: output register.
   logic [24:0]        press16_in;
   logic signed [23:0] press_out_ff, temp_out_ff;
   logic               clip_out_ff;

   assign press16_in = clamp_out(an15_ff, pr15_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         t_rmag1_ff <= t_rmag1_in;
         p_rmag1_ff <= p_rmag1_in;
         t_q1_ff <= t_q1_in;
         p_q1_ff <= p_q1_in;
         t_neg_ff[1] <= raw_t[23];
         p_neg_ff[1] <= raw_p[23];
      end
      if (stage_en[2]) begin
         t_mag_ff[2] <= t_mag2_in;
         p_mag_ff[2] <= p_mag2_in;
         t_s2_ff <= t_s2_in;
         p_s2_ff <= p_s2_in;
      end
      if (stage_en[3]) begin
         c30p3_ff <= c30p3_in;
         c21p3_ff <= c21p3_in;
         c1t3_ff <= c1t3_in;
         c01t_ff[3] <= c01t3_in;
      end
      if (stage_en[4]) begin
         h1_4_ff <= h1_4_in;
         g1_4_ff <= g1_4_in;
         tacc4_ff <= tacc4_in;
      end
      if (stage_en[5]) begin
         h1m5_ff <= h1m5_in;
         g1m5_ff <= g1m5_in;
         hn5_ff <= hn5_in;
         gn5_ff <= gn5_in;
         tm5_ff <= tm5_in;
         tn5_ff <= tacc4_ff[43];
      end
      if (stage_en[6]) begin
         hlo6_ff <= hlo6_in;
         hhi6_ff <= hhi6_in;
         glo6_ff <= glo6_in;
         ghi6_ff <= ghi6_in;
         hn6_ff <= hn5_ff;
         gn6_ff <= gn5_ff;
         tr6_ff <= tr6_in;
         tn6_ff <= tn5_ff;
      end
      if (stage_en[7]) begin
         hm7_ff <= hm7_in;
         gm7_ff <= gm7_in;
         hn7_ff <= hn6_ff;
         gn7_ff <= gn6_ff;
         temp_ff[7] <= $signed(temp7_in[23:0]);
         tclip_ff[7] <= temp7_in[24];
      end
      if (stage_en[8]) begin
         h2_8_ff <= h2_8_in;
         g2_8_ff <= g2_8_in;
      end
      if (stage_en[9]) begin
         h2m9_ff <= h2m9_in;
         g2m9_ff <= g2m9_in;
         hn9_ff <= hn9_in;
         gn9_ff <= gn9_in;
      end
      if (stage_en[10]) begin
         hlo10_ff <= hlo10_in;
         hhi10_ff <= hhi10_in;
         glo10_ff <= glo10_in;
         ghi10_ff <= ghi10_in;
         hn10_ff <= hn9_ff;
         gn10_ff <= gn9_ff;
      end
      if (stage_en[11]) begin
         h3m11_ff <= h3m11_in;
         g3m11_ff <= g3m11_in;
         hn11_ff <= hn10_ff;
         gn11_ff <= gn10_ff;
      end
      if (stage_en[12]) begin
         h3_12_ff <= h3_12_in;
         g3_12_ff <= g3_12_in;
      end
      if (stage_en[13]) begin
         acc13_ff <= acc13_in;
      end
      if (stage_en[14]) begin
         am14_ff <= am14_in;
         an14_ff <= acc13_ff[61];
      end
      if (stage_en[15]) begin
         pr15_ff <= pr15_in;
         an15_ff <= an14_ff;
      end
      if (stage_en[16]) begin
         press_out_ff <= $signed(press16_in[23:0]);
         temp_out_ff <= temp_ff[15];
         clip_out_ff <= press16_in[24] | tclip_ff[15];
      end
      for (int k = 2; k <= 8; k++) begin
         if (stage_en[k]) begin
            t_neg_ff[k] <= t_neg_ff[k-1];
            p_neg_ff[k] <= p_neg_ff[k-1];
         end
      end
      for (int k = 3; k <= 9; k++) begin
         if (stage_en[k]) begin
            t_mag_ff[k] <= t_mag_ff[k-1];
            p_mag_ff[k] <= p_mag_ff[k-1];
         end
      end
      for (int k = 4; k <= 12; k++) begin
         if (stage_en[k]) begin
            c01t_ff[k] <= c01t_ff[k-1];
         end
      end
      for (int k = 8; k <= 15; k++) begin
         if (stage_en[k]) begin
            temp_ff[k] <= temp_ff[k-1];
            tclip_ff[k] <= tclip_ff[k-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_DEPTH];
   assign rsp_tdata = {temp_out_ff, press_out_ff};
   assign rsp_tuser = clip_out_ff;

endmodule

### rtl/bptc_checker.sv
// Port-level checker for the compensation unit, attached by bind.
`include "baro_pressure_temp_compensation_unit_assert.svh"

module bptc_checker
   import bptc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result keeps its contents until its transfer.
   `BPTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // The pipeline must take input whenever the output side can drain.
   `BPTC_ASSERT_SAME(a_ready_when_draining, clock, reset, rsp_tready || !rsp_tvalid, req_tready, "input blocked while output drains")

   // A clamped result always sits on a rail of the 24-bit range.
   `BPTC_ASSERT_SAME(a_clip_on_rail, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata[23:0] == OUT_MAX) || (rsp_tdata[23:0] == OUT_MIN) || (rsp_tdata[47:24] == OUT_MAX) || (rsp_tdata[47:24] == OUT_MIN), "clip flag without a saturated value")

   // Reset empties the pipeline.
   `BPTC_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid, "result valid right after reset")

endmodule

bind baro_pressure_temp_compensation_unit bptc_checker u_bptc_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
